>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising edge of clk outside of reset.
`define RSTI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition seen at one edge leads to a consequence at the next.
`define RSTI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rsti_pkg.sv
// ----------------------------------------------------------------------------
// rsti_pkg
// Types, constants and helper functions of the radix string converter.
// ----------------------------------------------------------------------------
package rsti_pkg;

	localparam int VALUE_BITS = 31;
	localparam int WIDE_BITS  = VALUE_BITS + 4;
	localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_F = 8'h46;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_F = 8'h66;
	localparam logic [3:0] TEN         = 4'd10;
	localparam logic [3:0] DIGITS_MAX  = 4'd15;

	typedef enum logic [1:0] {
		MODE_BIN = 2'd0,
		MODE_OCT = 2'd1,
		MODE_DEC = 2'd2,
		MODE_HEX = 2'd3
	} mode_t;

	// Powers of ten, 10^0 through 10^14.
	localparam logic [63:0] POW10 [15] = '{
		64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
		64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
		64'd100000000000, 64'd1000000000000, 64'd10000000000000,
		64'd100000000000000
	};

	// Finished string handed from the accumulator to the output stage.
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  legal;
		logic                  sat;
	} fin_t;

	// Numeric base selected by a mode code.
	function automatic logic [4:0] base_of(input mode_t mode);
		logic [4:0] b;
		unique case (mode)
			MODE_BIN: b = 5'd2;
			MODE_OCT: b = 5'd8;
			MODE_DEC: b = 5'd10;
			MODE_HEX: b = 5'd16;
			default:  b = 5'd16;
		endcase
		return b;
	endfunction

	// Number of decimal digits of v, at least one, capped at fifteen.
	function automatic logic [3:0] dec_digits(input logic [VALUE_BITS-1:0] v);
		logic [3:0]  n;
		logic [63:0] vw;
		n  = 4'd1;
		vw = 64'(v);
		for (int k = 1; k < 15; k++) begin
			n = n + 4'(vw >= POW10[k]);
		end
		return (n > DIGITS_MAX) ? DIGITS_MAX : n;
	endfunction

endpackage

>>> rtl/rsti_accum.sv
// ----------------------------------------------------------------------------
// rsti_accum
// Request register, digit decode and saturating multiply-accumulate.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsti_accum import rsti_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] symbol,
	input  logic [1:0] mode,
	input  logic       last,
	input  logic       req_valid,
	output logic       req_stall,
	output logic       fin_valid,
	output fin_t       fin,
	input  logic       fin_take
);

	logic                  valid_s1;
	logic [7:0]            symbol_s1;
	mode_t                 mode_s1;
	logic                  last_s1;

	logic [VALUE_BITS-1:0] acc_q;
	logic                  legal_q;
	logic                  ovf_q;

	logic                  valid_s2;
	fin_t                  fin_s2;

	logic                  s2_free;
	logic                  go_s1;
	logic                  req_take;
	logic [4:0]            base;
	logic [3:0]            dig;
	logic                  dig_ok;
	logic [WIDE_BITS-1:0]  acc_w;
	logic [WIDE_BITS-1:0]  prod;
	logic [WIDE_BITS-1:0]  sum;
	logic                  over;
	logic [VALUE_BITS-1:0] acc_nxt;
	logic                  legal_nxt;
	logic                  ovf_nxt;

	assign s2_free   = !valid_s2 || fin_take;
	assign go_s1     = valid_s1 && (!last_s1 || s2_free);
	assign req_stall = valid_s1 && !go_s1;
	assign req_take  = req_valid && !req_stall;

	// Decode the character for the base of its own step.
	always_comb begin
		base   = base_of(mode_s1);
		dig    = '0;
		dig_ok = 1'b0;
		if (symbol_s1 >= CHAR_ZERO && symbol_s1 <= CHAR_NINE) begin
			dig    = 4'(symbol_s1 - CHAR_ZERO);
			dig_ok = {1'b0, dig} < base;
		end else if (mode_s1 == MODE_HEX) begin
			if (symbol_s1 >= CHAR_UPPER_A && symbol_s1 <= CHAR_UPPER_F) begin
				dig    = 4'(symbol_s1 - CHAR_UPPER_A) + TEN;
				dig_ok = 1'b1;
			end else if (symbol_s1 >= CHAR_LOWER_A && symbol_s1 <= CHAR_LOWER_F) begin
				dig    = 4'(symbol_s1 - CHAR_LOWER_A) + TEN;
				dig_ok = 1'b1;
			end
		end
	end

	// Scale by the base with shifts; any bit above the value width means overflow.
	always_comb begin
		acc_w = WIDE_BITS'(acc_q);
		case (mode_s1)
			MODE_BIN: prod = acc_w << 1;
			MODE_OCT: prod = acc_w << 3;
			MODE_DEC: prod = (acc_w << 3) + (acc_w << 1);
			default:  prod = acc_w << 4;
		endcase
		sum  = prod + WIDE_BITS'(dig);
		over = |sum[WIDE_BITS-1:VALUE_BITS];

		acc_nxt   = acc_q;
		legal_nxt = legal_q;
		ovf_nxt   = ovf_q;
		if (dig_ok) begin
			if (over) begin
				acc_nxt = VALUE_MAX;
				ovf_nxt = 1'b1;
			end else begin
				acc_nxt = sum[VALUE_BITS-1:0];
			end
		end else begin
			legal_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			acc_q    <= '0;
			legal_q  <= 1'b1;
			ovf_q    <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_take) begin
				valid_s1 <= 1'b1;
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end
			if (go_s1) begin
				if (last_s1) begin
					acc_q   <= '0;
					legal_q <= 1'b1;
					ovf_q   <= 1'b0;
				end else begin
					acc_q   <= acc_nxt;
					legal_q <= legal_nxt;
					ovf_q   <= ovf_nxt;
				end
			end
			if (go_s1 && last_s1) begin
				valid_s2 <= 1'b1;
			end else if (fin_take) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			symbol_s1 <= symbol;
			mode_s1   <= mode_t'(mode);
			last_s1   <= last;
		end
		if (go_s1 && last_s1) begin
			fin_s2.value <= legal_nxt ? acc_nxt : '0;
			fin_s2.legal <= legal_nxt;
			fin_s2.sat   <= legal_nxt && ovf_nxt;
		end
	end

	assign fin_valid = valid_s2;
	assign fin       = fin_s2;

	`RSTI_ASSERT_NEXT(a_state_cleared, go_s1 && last_s1,
		acc_q == '0 && legal_q && !ovf_q, "state not cleared after last character")
	`RSTI_ASSERT_NEXT(a_fin_held, valid_s2 && !fin_take,
		valid_s2 && $stable(fin_s2), "finished string lost while waiting")
	`RSTI_ASSERT(a_sat_clamped, valid_s2 && fin_s2.sat |-> fin_s2.legal && fin_s2.value == VALUE_MAX,
		"saturated result not clamped")

endmodule

>>> rtl/rsti_digits.sv
// ----------------------------------------------------------------------------
// rsti_digits
// Decimal digit count and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsti_digits import rsti_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fin_valid,
	input  fin_t                  fin,
	output logic                  fin_take,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [VALUE_BITS-1:0] value,
	output logic [3:0]            digit_count,
	output logic                  valid_res,
	output logic                  saturated
);

	logic                  valid_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [3:0]            count_q;
	logic                  legal_q;
	logic                  sat_q;
	logic                  room;

	assign room     = !valid_q || !res_stall;
	assign fin_take = fin_valid && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= fin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_take) begin
			value_q <= fin.value;
			count_q <= dec_digits(fin.value);
			legal_q <= fin.legal;
			sat_q   <= fin.sat;
		end
	end

	assign res_valid   = valid_q;
	assign value       = value_q;
	assign digit_count = count_q;
	assign valid_res   = legal_q;
	assign saturated   = sat_q;

	`RSTI_ASSERT(a_count_range, valid_q |-> count_q >= 4'd1 && count_q <= DIGITS_MAX,
		"digit count out of range")
	`RSTI_ASSERT(a_illegal_zero, valid_q && !legal_q |-> value_q == '0 && count_q == 4'd1 && !sat_q,
		"illegal string must give zero")
	`RSTI_ASSERT_NEXT(a_take_loads, fin_take, valid_q, "taken string did not reach the output")

endmodule

>>> rtl/radix_string_to_integer.sv
// ----------------------------------------------------------------------------
// radix_string_to_integer
// Converts an ASCII number string in base 2, 8, 10 or 16 into a binary value.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake             payload
//   request   in         req_valid/req_stall   symbol, mode, last
//   result    out        res_valid/res_stall   value, digit_count, valid_res, saturated
//
// One character is taken per clock cycle while req_stall is low; the
// multiply-accumulate is a single shift-and-add step on the character register, so
// strings stream back to back. A result passes the character, finished-string and
// output registers in turn. Reset is asynchronous and active low; it empties all
// stages and clears the accumulator. A stalled result holds the output register; only
// a last character finding both later registers full and stalled raises req_stall.
//
// Each character is decoded against the base of its own request. Digits fold
// into the accumulator as value = value * base + digit. If that would pass the
// largest representable value, the accumulator clamps there and the overflow
// flag is set for the rest of the string. A character that is not a legal
// digit of its base leaves the accumulator alone and marks the string bad; a
// bad string reports value zero, one digit and no saturation. Hex accepts
// both upper and lower case letters. The decimal digit count of the final
// value is computed in the output stage from a bank of constant compares.
// ----------------------------------------------------------------------------
module radix_string_to_integer import rsti_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [7:0]            symbol,
	input  logic [1:0]            mode,
	input  logic                  last,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [VALUE_BITS-1:0] value,
	output logic [3:0]            digit_count,
	output logic                  valid_res,
	output logic                  saturated
);

	// Finished string between the accumulator and the output register.
	logic fin_valid;
	fin_t fin;
	logic fin_take;

	rsti_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.symbol    (symbol),
		.mode      (mode),
		.last      (last),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.fin_valid (fin_valid),
		.fin       (fin),
		.fin_take  (fin_take)
	);

	rsti_digits u_digits (
		.clk         (clk),
		.arst_n      (arst_n),
		.fin_valid   (fin_valid),
		.fin         (fin),
		.fin_take    (fin_take),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.value       (value),
		.digit_count (digit_count),
		.valid_res   (valid_res),
		.saturated   (saturated)
	);

endmodule
